/* hw/rtl/fch_pkg.sv */
`timescale 1ns / 1ps

package fch_pkg;

    localparam int CurvePointsDefault = 8;
    localparam int TempW   = 16;
    localparam int LevelW  = 16;
    localparam int MarginW = 15;
    localparam int IndexW  = 3;
    localparam int DivSteps = 16;
    localparam int DivCntW  = $clog2(DivSteps);

    localparam logic [MarginW-1:0] MarginReset = 15'd32;
    localparam logic [LevelW-1:0]  LevelOne    = 16'd32768;

    localparam logic ReqSample = 1'b0;
    localparam logic ReqWrite  = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic signed [TempW-1:0]  temperature;
        logic [IndexW-1:0]        point_index;
        logic signed [TempW-1:0]  point_temperature;
        logic [LevelW-1:0]        point_level;
    } t_req;

    typedef struct packed {
        logic [LevelW-1:0] fan_level;
        logic              recomputed;
    } t_res;

    typedef struct packed {
        logic signed [TempW-1:0] temp;
        logic [LevelW-1:0]       level;
    } t_point;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HYST,
        S_SCAN,
        S_SEG,
        S_DINIT,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic wr;
        logic advance;
        logic take;
        logic seg;
        logic mul;
        logic dinit;
        logic dstep;
        logic lvl_rd;
        logic lvl_base;
        logic lvl_div;
    } t_dp_cmd;

    typedef struct packed {
        logic need;
        logic hit;
        logic first;
        logic last;
        logic flat;
        logic div_done;
    } t_dp_sts;

endpackage

/* hw/rtl/fch_ctrl.sv */
`timescale 1ns / 1ps

module fch_ctrl import fch_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_req_type,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy,
    output logic    o_strobe
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_req_type == ReqSample)) begin
                    n_state = S_HYST;
                end
            end
            S_HYST: begin
                n_state = i_sts.need ? S_SCAN : S_OUT;
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    n_state = i_sts.first ? S_OUT : S_SEG;
                end else if (i_sts.last) begin
                    n_state = S_OUT;
                end
            end
            S_SEG: begin
                n_state = i_sts.flat ? S_OUT : S_DINIT;
            end
            S_DINIT: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        o_busy   = 1'b1;
        o_strobe = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = w_accept && (i_req_type == ReqSample);
                o_cmd.wr   = w_accept && (i_req_type == ReqWrite);
            end
            S_HYST: begin
                o_cmd.advance = 1'b1;
                o_cmd.take    = 1'b1;
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.lvl_rd = i_sts.first;
                    o_cmd.seg    = !i_sts.first;
                end else if (i_sts.last) begin
                    o_cmd.lvl_rd = 1'b1;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_SEG: begin
                o_cmd.mul      = 1'b1;
                o_cmd.lvl_base = i_sts.flat;
            end
            S_DINIT: begin
                o_cmd.dinit = 1'b1;
            end
            S_DIV: begin
                o_cmd.dstep = 1'b1;
            end
            S_FIN: begin
                o_cmd.lvl_div = 1'b1;
            end
            S_OUT: begin
                o_strobe = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

/* hw/rtl/fch_datapath.sv */
`timescale 1ns / 1ps

module fch_datapath import fch_pkg::*; #(
    parameter int CURVE_POINTS = CurvePointsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_req               i_req,
    input  logic               i_cfg_we,
    input  logic [MarginW-1:0] i_cfg_wdata,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output t_res               o_res
);

    localparam int AW = (CURVE_POINTS > 1) ? $clog2(CURVE_POINTS) : 1;
    localparam logic [AW-1:0] LastIdx = AW'(CURVE_POINTS - 1);

    t_point r_mem [CURVE_POINTS];
    t_point r_rd;
    t_point r_lo;
    t_point w_wpoint;
    logic [AW-1:0] w_waddr;
    logic          w_in_range;

    logic [AW-1:0] r_raddr;
    logic [AW-1:0] r_cnt;

    logic [MarginW-1:0]      r_margin;
    logic signed [TempW-1:0] r_temp;
    logic signed [TempW-1:0] r_held_temp;
    logic [LevelW-1:0]       r_held_level;
    logic                    r_have;
    logic                    r_fresh;

    logic signed [TempW:0] w_diff;
    logic [TempW:0]        w_mag;

    logic signed [TempW:0] w_dt;
    logic signed [TempW:0] w_dx;
    logic signed [LevelW:0] w_dl;
    logic signed [TempW:0]  r_dt;
    logic [TempW-1:0]       r_dx;
    logic signed [LevelW:0] r_dl;
    logic [LevelW-1:0]      r_base;

    logic [LevelW:0]          w_dl_mag;
    logic [TempW+LevelW-1:0]  r_prod;
    logic [TempW+LevelW-1:0]  w_sum;
    logic [TempW-1:0]         r_rem;
    logic [LevelW-1:0]        r_quo;
    logic [DivCntW-1:0]       r_dcnt;
    logic [TempW:0]           w_trial;
    logic [TempW:0]           w_trial_sub;
    logic                     w_ge;

    // table write, level saturated to one
    assign w_waddr     = AW'(i_req.point_index);
    assign w_in_range  = (32'(i_req.point_index) < 32'(CURVE_POINTS));
    assign w_wpoint.temp  = i_req.point_temperature;
    assign w_wpoint.level = (i_req.point_level > LevelOne) ? LevelOne : i_req.point_level;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && w_in_range) begin
            r_mem[w_waddr] <= w_wpoint;
        end
        r_rd <= r_mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raddr <= '0;
        end else if (i_cmd.advance) begin
            r_raddr <= (r_raddr == LastIdx) ? '0 : r_raddr + AW'(1);
            r_cnt   <= r_raddr;
            r_lo    <= r_rd;
        end
    end

    assign w_diff = {r_temp[TempW-1], r_temp} - {r_held_temp[TempW-1], r_held_temp};
    assign w_mag  = w_diff[TempW] ? 17'(-w_diff) : 17'(w_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin     <= MarginReset;
            r_held_temp  <= '0;
            r_held_level <= '0;
            r_have       <= 1'b0;
            r_fresh      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_margin <= i_cfg_wdata;
            end
            if (i_cmd.take) begin
                r_fresh <= o_sts.need;
                if (o_sts.need) begin
                    r_held_temp <= r_temp;
                    r_have      <= 1'b1;
                end
            end
            if (i_cmd.lvl_rd) begin
                r_held_level <= r_rd.level;
            end else if (i_cmd.lvl_base) begin
                r_held_level <= r_base;
            end else if (i_cmd.lvl_div) begin
                r_held_level <= r_dl[LevelW] ? (r_base - r_quo) : (r_base + r_quo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_temp <= i_req.temperature;
        end
    end

    // segment between r_lo and r_rd
    assign w_dt = {r_rd.temp[TempW-1], r_rd.temp} - {r_lo.temp[TempW-1], r_lo.temp};
    assign w_dx = {r_temp[TempW-1], r_temp} - {r_lo.temp[TempW-1], r_lo.temp};
    assign w_dl = $signed({1'b0, r_rd.level}) - $signed({1'b0, r_lo.level});

    assign w_dl_mag = r_dl[LevelW] ? 17'(-r_dl) : 17'(r_dl);
    assign w_sum    = r_prod + (TempW+LevelW)'(r_dt[TempW-1:1]);

    assign w_trial     = {r_rem, r_quo[LevelW-1]};
    assign w_ge        = (w_trial >= {1'b0, r_dt[TempW-1:0]});
    assign w_trial_sub = w_trial - {1'b0, r_dt[TempW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.seg) begin
            r_dt   <= w_dt;
            r_dx   <= w_dx[TempW-1:0];
            r_dl   <= w_dl;
            r_base <= r_lo.level;
        end
        if (i_cmd.mul) begin
            r_prod <= w_dl_mag[LevelW-1:0] * r_dx;
        end
        if (i_cmd.dinit) begin
            r_rem  <= w_sum[TempW+LevelW-1:LevelW];
            r_quo  <= w_sum[LevelW-1:0];
            r_dcnt <= '0;
        end else if (i_cmd.dstep) begin
            r_rem  <= w_ge ? w_trial_sub[TempW-1:0] : w_trial[TempW-1:0];
            r_quo  <= {r_quo[LevelW-2:0], w_ge};
            r_dcnt <= r_dcnt + DivCntW'(1);
        end
    end

    assign o_sts.need     = !r_have || (w_mag >= 17'(r_margin));
    assign o_sts.hit      = (r_temp <= r_rd.temp);
    assign o_sts.first    = (r_cnt == '0);
    assign o_sts.last     = (r_cnt == LastIdx);
    assign o_sts.flat     = (r_dl == '0) || r_dt[TempW] || (r_dt == '0);
    assign o_sts.div_done = (r_dcnt == DivCntW'(DivSteps - 1));

    assign o_res.fan_level  = r_held_level;
    assign o_res.recomputed = r_fresh;

endmodule

/* hw/rtl/fan_curve_hysteresis_unit.sv */
`timescale 1ns / 1ps

// Fan curve with hysteresis: temperature (Q12.4) in, fan level (Q1.15) out.
// Request channel: a beat on i_req is taken when start is high and busy is
// low. A write beat (req_type 1) loads one curve point in that same cycle,
// leaves busy low and gives no result. A sample beat (req_type 0) gives
// exactly one result beat on o_res, marked by o_strobe for one cycle.
// A sample either returns the held level or recomputes it from the
// curve: the points are scanned in order (up to CURVE_POINTS), and a
// segment that is not flat then needs the multiply and the 16-step
// serial divider. busy stays high until the result cycle ends, so one
// sample is in flight at a time.
// Margin register: i_cfg_we / i_cfg_wdata, write only while idle.
// The receiver cannot stall; o_res is valid only in the o_strobe cycle.
// Reset clears the margin to 32 and the held level, temperature and
// history; curve points are undefined until written.
module fan_curve_hysteresis_unit import fch_pkg::*; #(
    parameter int CURVE_POINTS = CurvePointsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    input  logic               i_cfg_we,
    input  logic [MarginW-1:0] i_cfg_wdata,
    output logic               o_strobe,
    output t_res               o_res
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    fch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (busy),
        .o_strobe   (o_strobe)
    );

    fch_datapath #(
        .CURVE_POINTS (CURVE_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res       (o_res)
    );

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.req_type == ReqSample)) |=> (busy && !o_strobe))
        else $error("sample not taken into work");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.req_type == ReqWrite)) |=> (!busy && !o_strobe))
        else $error("write beat produced activity");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import fch_pkg::*;

    localparam int NPTS         = CurvePointsDefault;
    localparam int CycleLimit   = 1_000_000;
    localparam int SettleCycles = 40;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    t_req               i_req       = '0;
    logic               i_cfg_we    = 1'b0;
    logic [MarginW-1:0] i_cfg_wdata = '0;
    logic               o_strobe;
    t_res               o_res;

    int cycle_count  = 0;
    int margins_used = 0;

    fan_curve_hysteresis_unit #(.CURVE_POINTS(NPTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_res       (o_res)
    );

    class fan_curve_scoreboard;
        int   curve_temp[NPTS];
        int   curve_level[NPTS];
        int   held_temp;
        int   held_level;
        bit   primed;
        int   margin;
        t_res level_queue[$];
        int   mismatches;
        int   samples;
        int   fresh;
        int   writes;

        function new();
            foreach (curve_temp[k]) begin
                curve_temp[k]  = 0;
                curve_level[k] = 0;
            end
            held_temp  = 0;
            held_level = 0;
            primed     = 1'b0;
            margin     = int'(MarginReset);
            mismatches = 0;
            samples    = 0;
            fresh      = 0;
            writes     = 0;
        endfunction

        function int curve_level_at(int t);
            longint dl, dx, dt, num, mag, q;
            if (t <= curve_temp[0])
                return curve_level[0];
            for (int k = 0; k < NPTS - 1; k++) begin
                if (t <= curve_temp[k+1]) begin
                    if (curve_level[k] == curve_level[k+1])
                        return curve_level[k];
                    dt = longint'(curve_temp[k+1]) - curve_temp[k];
                    dx = longint'(t) - curve_temp[k];
                    dl = longint'(curve_level[k+1]) - curve_level[k];
                    if (dt <= 0)
                        return curve_level[k];
                    num = dl * dx;
                    mag = (num < 0) ? -num : num;
                    // round half away from zero
                    q = (mag + dt / 2) / dt;
                    if (num < 0)
                        q = -q;
                    return int'(curve_level[k] + q);
                end
            end
            return curve_level[NPTS-1];
        endfunction

        function void note_beat(t_req r);
            int   t;
            int   gap;
            t_res want;
            if (r.req_type == ReqWrite) begin
                curve_temp[int'(r.point_index)]  = int'($signed(r.point_temperature));
                curve_level[int'(r.point_index)] =
                    (r.point_level > LevelOne) ? int'(LevelOne) : int'(r.point_level);
                writes++;
            end else begin
                t   = int'($signed(r.temperature));
                gap = t - held_temp;
                if (gap < 0)
                    gap = -gap;
                want.recomputed = 1'b0;
                if (!primed || gap >= margin) begin
                    held_level      = curve_level_at(t);
                    held_temp       = t;
                    primed          = 1'b1;
                    want.recomputed = 1'b1;
                    fresh++;
                end
                want.fan_level = 16'(held_level);
                level_queue.push_back(want);
                samples++;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (level_queue.size() == 0) begin
                $error("result beat with no sample pending: fan_level %0d recomputed %0d",
                       got.fan_level, got.recomputed);
                mismatches++;
                return;
            end
            want = level_queue.pop_front();
            if (got.fan_level !== want.fan_level) begin
                $error("fan_level: expected %0d, got %0d", want.fan_level, got.fan_level);
                mismatches++;
            end
            if (got.recomputed !== want.recomputed) begin
                $error("recomputed: expected %0d, got %0d", want.recomputed, got.recomputed);
                mismatches++;
            end
        endfunction
    endclass

    fan_curve_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_res);
    end

    function automatic t_req sample_beat(int t);
        t_req r;
        r.req_type          = ReqSample;
        r.temperature       = 16'(t);
        r.point_index       = 3'($urandom);
        r.point_temperature = 16'($urandom);
        r.point_level       = 16'($urandom);
        return r;
    endfunction

    function automatic t_req write_beat(int idx, int t, int lvl);
        t_req r;
        r.req_type          = ReqWrite;
        r.temperature       = 16'($urandom);
        r.point_index       = 3'(idx);
        r.point_temperature = 16'(t);
        r.point_level       = 16'(lvl);
        return r;
    endfunction

    function automatic int pick_level();
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(32769, 65535));
        return int'($urandom_range(0, 32768));
    endfunction

    function automatic int pick_temp();
        int m;
        int t;
        m = sb.margin;
        case ($urandom_range(0, 9))
            0, 1: t = int'($urandom_range(0, 65535)) - 32768;
            2, 3: t = sb.curve_temp[$urandom_range(0, NPTS - 1)]
                      + int'($urandom_range(0, 6)) - 3;
            4: t = sb.held_temp + ($urandom_range(0, 1) ? m : -m)
                   + int'($urandom_range(0, 2)) - 1;
            default: t = sb.held_temp + int'($urandom_range(0, 2 * m + 4)) - (m + 2);
        endcase
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return t;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input t_req r);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sb.note_beat(r);
        @(negedge i_clk);
    endtask

    task automatic pause_beats(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (sb.level_queue.size() != 0 || busy)
            @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic set_margin(int m);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 15'(m);
        sb.margin = m;
        margins_used++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // 0: ascending, wide steps; 1: ascending, tiny steps; 2: unordered
    task automatic load_curve(int kind);
        int t;
        int lvl;
        t   = (kind == 1) ? int'($urandom_range(0, 4000)) - 2000
                          : int'($urandom_range(0, 24000)) - 32768;
        lvl = int'($urandom_range(0, 32768));
        for (int k = 0; k < NPTS; k++) begin
            if (kind == 2)
                t = int'($urandom_range(0, 65535)) - 32768;
            else if (k > 0)
                t += (kind == 1) ? int'($urandom_range(0, 4)) : int'($urandom_range(0, 9000));
            if (t > 32767)
                t = 32767;
            if ($urandom_range(0, 4) != 0)
                lvl = pick_level();
            send_beat(write_beat(k, t, lvl));
        end
    endtask

    task automatic run_phase(int n, int max_gap);
        int done;
        int burst;
        int roll;
        int idx;
        int t;
        done = 0;
        while (done < n) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    load_curve($urandom_range(0, 2));
                    done += NPTS;
                end else if (roll < 9) begin
                    idx = $urandom_range(0, NPTS - 1);
                    if (roll < 6)
                        t = sb.curve_temp[idx] + int'($urandom_range(0, 40)) - 20;
                    else
                        t = int'($urandom_range(0, 65535)) - 32768;
                    if (t > 32767)
                        t = 32767;
                    if (t < -32768)
                        t = -32768;
                    send_beat(write_beat(idx, t, pick_level()));
                    done++;
                end else begin
                    send_beat(sample_beat(pick_temp()));
                    done++;
                end
            end
            pause_beats((max_gap == 0) ? 0 : $urandom_range(0, max_gap));
        end
    endtask

    initial begin
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: table with clamp ends, flat, rising, falling, tied and saturated points
        send_beat(write_beat(0, -32768, 0));
        send_beat(write_beat(1, -1600, 0));
        send_beat(write_beat(2, 400, 8000));
        send_beat(write_beat(3, 640, 20000));
        send_beat(write_beat(4, 800, 16000));
        send_beat(write_beat(5, 800, 30000));
        send_beat(write_beat(6, 1200, 65535));
        send_beat(write_beat(7, 32767, 32768));
        send_beat(sample_beat(-32768));
        send_beat(sample_beat(32767));
        send_beat(sample_beat(32757));
        send_beat(sample_beat(500));
        send_beat(sample_beat(700));
        send_beat(sample_beat(-1000));
        send_beat(sample_beat(1000));
        send_beat(sample_beat(1010));
        set_margin(0);
        send_beat(sample_beat(1010));
        send_beat(sample_beat(1010));
        send_beat(write_beat(3, 640, 4000));
        send_beat(sample_beat(600));
        set_margin(32767);
        send_beat(sample_beat(-32768));
        send_beat(sample_beat(0));
        send_beat(sample_beat(32766));
        send_beat(sample_beat(32767));

        set_margin(32);
        run_phase(250, 0);
        set_margin(1);
        load_curve(1);
        run_phase(250, 4);
        set_margin(0);
        run_phase(250, 12);
        set_margin(32767);
        load_curve(0);
        run_phase(250, 2);
        set_margin($urandom_range(2, 32766));
        load_curve(2);
        run_phase(250, 8);
        set_margin($urandom_range(0, 300));
        load_curve(0);
        run_phase(250, 0);
        set_margin($urandom_range(0, 32767));
        run_phase(250, 6);

        settle();
        $display("tb_top: %0d samples (%0d recomputed, %0d held), %0d point writes",
                 sb.samples, sb.fresh, sb.samples - sb.fresh, sb.writes);
        $display("tb_top: %0d margin settings incl. 0 and 32767, %0d mismatches",
                 margins_used, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/fch_pkg.sv
hw/rtl/fch_ctrl.sv
hw/rtl/fch_datapath.sv
hw/rtl/fan_curve_hysteresis_unit.sv
tb/tb_top.sv
